// ===== src/clbu_pkg.sv =====
// clbu_pkg: shared types, opcodes and constants of the cpu/gpu load balancer
// used by the channel interfaces and by cpu_gpu_load_balancer_unit
`default_nettype none

package clbu_pkg;

  // default sizing of the cost tables and of the cost fixed point
  localparam int CLBU_KINDS     = 64;
  localparam int CLBU_FRAC_BITS = 16;

  // load totals and costs
  localparam int LOAD_W = 48;
  localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

  // unit cost, size and their product
  localparam int COST_W = 32;
  localparam int SIZE_W = 31;
  localparam int PROD_W = COST_W + SIZE_W;

  // configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 64;
  localparam logic [1:0] REG_SCHED_EN  = 2'd0;
  localparam logic [1:0] REG_GPU_LIMIT = 2'd1;
  localparam logic [1:0] REG_CPU_LIMIT = 2'd2;

  // request opcodes
  typedef enum logic [2:0] {
    OP_KERNEL  = 3'd0,
    OP_READ    = 3'd1,
    OP_WRITE   = 3'd2,
    OP_COPY    = 3'd3,
    OP_RELEASE = 3'd4,
    OP_LOAD    = 3'd5
  } op_t;

  // request word
  typedef struct packed {
    logic [2:0]        opcode;
    logic [5:0]        kind;
    logic [SIZE_W-1:0] size;
    logic              prev_device;
    logic              forced_device;
    logic [LOAD_W-1:0] release_amount;
    logic [COST_W-1:0] cost_value;
    logic              cost_side;
  } req_t;

  // result word
  typedef struct packed {
    logic              device;
    logic [LOAD_W-1:0] burden;
    logic [LOAD_W-1:0] cpu_total;
    logic [LOAD_W-1:0] gpu_total;
  } rsp_t;

  // fields that travel with a request through the pipeline
  typedef struct packed {
    logic [2:0]        op;
    logic              prev;
    logic              forced;
    logic              cside;
    logic [LOAD_W-1:0] rel;
  } ctl_t;

endpackage

`default_nettype wire

// ===== src/clbu_req_if.sv =====
// clbu_req_if: request channel of the load balancer, valid/ready plus word
// depends on clbu_pkg for the request word type
`default_nettype none

interface clbu_req_if
  import clbu_pkg::*;
  ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/clbu_rsp_if.sv =====
// clbu_rsp_if: result channel of the load balancer, valid/ready plus word
// depends on clbu_pkg for the result word type
`default_nettype none

interface clbu_rsp_if
  import clbu_pkg::*;
  ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/cpu_gpu_load_balancer_unit.sv =====
// cpu_gpu_load_balancer_unit: places requests on cpu or gpu, keeps load totals
// depends on clbu_pkg, clbu_req_if and clbu_rsp_if
//
//   channel  dir  handshake                 word
//   req      in   req.valid / req.ready     opcode, kind, size, devices, amounts
//   rsp      out  rsp.valid / rsp.ready     device, burden, cpu/gpu totals
//   apb      in   psel, penable, pwrite     sched enable, gpu/cpu limits
//
// one request word per cycle while the result channel is not stalled
// stages: cost table read, cost multiply, placement and load total update
// the load totals are updated in the last stage and fed back within it
// rst is synchronous: clears totals and pipeline valids, sets config defaults;
// the cost tables are not cleared and hold garbage until loaded
// a stalled result holds the output register; earlier stages fill bubbles
`default_nettype none

module cpu_gpu_load_balancer_unit
  import clbu_pkg::*;
#(
  parameter int KINDS     = CLBU_KINDS,
  parameter int FRAC_BITS = CLBU_FRAC_BITS
) (
  input  wire               clk,
  input  wire               rst,
  clbu_req_if.sink          req,
  clbu_rsp_if.source        rsp,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [APB_AW-1:0] paddr,
  input  wire  [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = $clog2(KINDS);
  localparam logic [8:0]    KINDS_N    = 9'(KINDS);
  localparam logic [AW-1:0] SLOT_READ  = AW'(KINDS - 3);
  localparam logic [AW-1:0] SLOT_WRITE = AW'(KINDS - 2);
  localparam logic [AW-1:0] SLOT_COPY  = AW'(KINDS - 1);

  // configuration registers
  logic              sched_en;
  logic [LOAD_W-1:0] gpu_limit;
  logic [LOAD_W-1:0] cpu_limit;
  logic              cfg_wr;

  // cost tables
  logic [COST_W-1:0] cpu_mem [KINDS];
  logic [COST_W-1:0] gpu_mem [KINDS];

  // pipeline
  logic              s1_valid, s2_valid, out_valid;
  ctl_t              s1_ctl, s2_ctl;
  logic [SIZE_W-1:0] s1_size;
  logic              s1_cost_ok;
  logic [COST_W-1:0] cpu_rd, gpu_rd;
  logic [LOAD_W-1:0] s2_cc, s2_gc;
  rsp_t              out_word;

  // handshake
  logic out_free, s2_free, s1_free, s1_adv, ex_fire, accept;

  // first stage decode
  logic [AW-1:0] rd_addr;
  logic          kind_ok;
  logic          cost_ok;

  // multiply
  logic [PROD_W-1:0] cpu_prod, gpu_prod, cpu_shift, gpu_shift;
  logic [LOAD_W-1:0] cc, gc;

  // execute
  logic              cpu_lt;
  logic [LOAD_W:0]   cpu_sum, gpu_sum, chg_sum;
  logic              dev;
  logic [LOAD_W-1:0] burden;
  logic              do_charge, do_release;
  logic [LOAD_W-1:0] base_load, chg_val, rel_val;
  logic [LOAD_W-1:0] cpu_load, gpu_load, cpu_load_next, gpu_load_next;

  // apb write and read back
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sched_en  <= 1'b1;
      gpu_limit <= LOAD_MAX;
      cpu_limit <= LOAD_MAX;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        REG_SCHED_EN:  sched_en  <= pwdata[0];
        REG_GPU_LIMIT: gpu_limit <= pwdata[LOAD_W-1:0];
        REG_CPU_LIMIT: cpu_limit <= pwdata[LOAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_SCHED_EN:  prdata = APB_DW'(sched_en);
      REG_GPU_LIMIT: prdata = APB_DW'(gpu_limit);
      REG_CPU_LIMIT: prdata = APB_DW'(cpu_limit);
      default:       prdata = '0;
    endcase
  end

  // stage advance
  assign out_free  = !out_valid || rsp.ready;
  assign ex_fire   = s2_valid && out_free;
  assign s2_free   = !s2_valid || out_free;
  assign s1_adv    = s1_valid && s2_free;
  assign s1_free   = !s1_valid || s2_free;
  assign req.ready = s1_free;
  assign accept    = req.valid && s1_free;

  // table address per opcode
  assign kind_ok = 9'(req.data.kind) < KINDS_N;

  always_comb begin
    case (op_t'(req.data.opcode))
      OP_KERNEL: begin
        rd_addr = AW'(req.data.kind);
        cost_ok = kind_ok;
      end
      OP_READ: begin
        rd_addr = SLOT_READ;
        cost_ok = 1'b1;
      end
      OP_WRITE: begin
        rd_addr = SLOT_WRITE;
        cost_ok = 1'b1;
      end
      OP_COPY: begin
        rd_addr = SLOT_COPY;
        cost_ok = 1'b1;
      end
      default: begin
        rd_addr = AW'(req.data.kind);
        cost_ok = 1'b0;
      end
    endcase
  end

  // cost tables: written by a cost load at acceptance, read at acceptance
  always_ff @(posedge clk) begin
    if (accept && op_t'(req.data.opcode) == OP_LOAD && kind_ok) begin
      if (req.data.cost_side) begin
        gpu_mem[AW'(req.data.kind)] <= req.data.cost_value;
      end else begin
        cpu_mem[AW'(req.data.kind)] <= req.data.cost_value;
      end
    end
    if (accept) begin
      cpu_rd <= cpu_mem[rd_addr];
      gpu_rd <= gpu_mem[rd_addr];
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_ctl.op     <= req.data.opcode;
      s1_ctl.prev   <= req.data.prev_device;
      s1_ctl.forced <= req.data.forced_device;
      s1_ctl.cside  <= req.data.cost_side;
      s1_ctl.rel    <= req.data.release_amount;
      s1_size       <= req.data.size;
      s1_cost_ok    <= cost_ok;
    end
  end

  // unit cost times size, drop fraction, saturate
  assign cpu_prod  = PROD_W'(cpu_rd) * PROD_W'(s1_size);
  assign gpu_prod  = PROD_W'(gpu_rd) * PROD_W'(s1_size);
  assign cpu_shift = cpu_prod >> FRAC_BITS;
  assign gpu_shift = gpu_prod >> FRAC_BITS;

  always_comb begin
    if (!s1_cost_ok) begin
      cc = '0;
      gc = '0;
    end else begin
      cc = (|cpu_shift[PROD_W-1:LOAD_W]) ? LOAD_MAX : cpu_shift[LOAD_W-1:0];
      gc = (|gpu_shift[PROD_W-1:LOAD_W]) ? LOAD_MAX : gpu_shift[LOAD_W-1:0];
    end
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
    if (s1_adv) begin
      s2_ctl <= s1_ctl;
      s2_cc  <= cc;
      s2_gc  <= gc;
    end
  end

  // placement decision
  assign cpu_sum = {1'b0, cpu_load} + {1'b0, s2_cc};
  assign gpu_sum = {1'b0, gpu_load} + {1'b0, s2_gc};
  assign cpu_lt  = cpu_sum < gpu_sum;

  always_comb begin
    dev        = 1'b0;
    burden     = '0;
    do_charge  = 1'b0;
    do_release = 1'b0;
    case (op_t'(s2_ctl.op))
      OP_KERNEL: begin
        dev       = sched_en ? !cpu_lt : s2_ctl.forced;
        burden    = dev ? s2_gc : s2_cc;
        do_charge = 1'b1;
      end
      OP_READ: begin
        if (!sched_en) begin
          dev = s2_ctl.forced;
        end else if (gpu_load < cpu_load) begin
          dev = 1'b1;
        end else begin
          dev = !(gpu_load > gpu_limit);
        end
        burden    = s2_ctl.prev ? s2_gc : s2_cc;
        do_charge = 1'b1;
      end
      OP_WRITE: begin
        if (!sched_en) begin
          dev = s2_ctl.forced;
        end else if (cpu_load < gpu_load) begin
          dev = 1'b0;
        end else begin
          dev = cpu_load > cpu_limit;
        end
        burden    = s2_ctl.prev ? s2_gc : s2_cc;
        do_charge = 1'b1;
      end
      OP_COPY: begin
        dev       = sched_en ? !(cpu_load < gpu_load) : s2_ctl.forced;
        burden    = s2_ctl.prev ? s2_gc : s2_cc;
        do_charge = 1'b1;
      end
      OP_RELEASE: begin
        dev        = s2_ctl.prev;
        burden     = s2_ctl.rel;
        do_release = 1'b1;
      end
      OP_LOAD: begin
        dev = s2_ctl.cside;
      end
      default: ;
    endcase
  end

  // saturating charge and floored release on the chosen device
  assign base_load = dev ? gpu_load : cpu_load;
  assign chg_sum   = {1'b0, base_load} + {1'b0, burden};
  assign chg_val   = chg_sum[LOAD_W] ? LOAD_MAX : chg_sum[LOAD_W-1:0];
  assign rel_val   = (base_load > burden) ? (base_load - burden) : '0;

  always_comb begin
    cpu_load_next = cpu_load;
    gpu_load_next = gpu_load;
    if (do_charge || do_release) begin
      if (dev) begin
        gpu_load_next = do_charge ? chg_val : rel_val;
      end else begin
        cpu_load_next = do_charge ? chg_val : rel_val;
      end
    end
  end

  // load totals and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_load  <= '0;
      gpu_load  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ex_fire) begin
        cpu_load  <= cpu_load_next;
        gpu_load  <= gpu_load_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (ex_fire) begin
      out_word.device    <= dev;
      out_word.burden    <= burden;
      out_word.cpu_total <= cpu_load_next;
      out_word.gpu_total <= gpu_load_next;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_word;

  // totals move only when a word leaves the last stage
  a_totals_hold: assert property (@(posedge clk) disable iff (rst)
    !ex_fire |=> $stable(cpu_load) && $stable(gpu_load))
    else $error("load total changed without an executed word");

  // a release never raises a total
  a_release_down: assert property (@(posedge clk) disable iff (rst)
    ex_fire && s2_ctl.op == OP_RELEASE |=>
      (cpu_load <= $past(cpu_load)) && (gpu_load <= $past(gpu_load)))
    else $error("release raised a load total");

  // a charge never lowers a total
  a_charge_up: assert property (@(posedge clk) disable iff (rst)
    ex_fire && (s2_ctl.op == OP_KERNEL || s2_ctl.op == OP_READ ||
                s2_ctl.op == OP_WRITE || s2_ctl.op == OP_COPY) |=>
      (cpu_load >= $past(cpu_load)) && (gpu_load >= $past(gpu_load)))
    else $error("charge lowered a load total");

  // a new result only comes from an occupied last stage
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s2_valid))
    else $error("result word appeared without a word in the last stage");

endmodule

`default_nettype wire
